### design/adcc_pkg.sv
package adcc_pkg;

    // Field widths
    localparam int LEVEL_BITS = 12;
    localparam int CODE_BITS  = 15;
    localparam int CTRL_BITS  = 8;
    localparam int PADDR_BITS = 5;

    // Control register bit positions
    localparam int BIT_ADON = 0;
    localparam int BIT_ADIF = 1;
    localparam int BIT_GO   = 2;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Converter phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ACQ  = 2'd1;
    localparam logic [1:0] PH_CONV = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CONVERTER_BITS = 3'd0;
    localparam logic [2:0] REG_SPLIT_RESULT   = 3'd1;
    localparam logic [2:0] REG_RIGHT_JUSTIFY  = 3'd2;
    localparam logic [2:0] REG_ANALOG_MASK    = 3'd3;
    localparam logic [2:0] REG_REF_HIGH_CHAN  = 3'd4;
    localparam logic [2:0] REG_REF_LOW_CHAN   = 3'd5;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            write_data;
        logic [LEVEL_BITS-1:0] sample_level;
        logic [LEVEL_BITS-1:0] ref_high_level;
        logic [LEVEL_BITS-1:0] ref_low_level;
        logic [LEVEL_BITS-1:0] supply_level;
    } adcc_in_t;

    typedef struct packed {
        logic [7:0] control_value;
        logic [7:0] result_high;
        logic [7:0] result_low;
        logic [2:0] selected_channel;
        logic       busy_res;
        logic       interrupt_pulse;
    } adcc_out_t;

    // Operands handed to the divider
    typedef struct packed {
        logic [LEVEL_BITS-1:0] sample;
        logic [LEVEL_BITS-1:0] ref_high;
        logic [LEVEL_BITS-1:0] ref_low;
        logic [3:0]            conv_bits;
    } adcc_div_req_t;

    // Half of the conversion clock period in ticks, from the clock select bits
    function automatic logic [5:0] half_tad(input logic [1:0] clk_sel);
        logic [5:0] h;
        case (clk_sel)
            2'd0:    h = 6'd1;
            2'd1:    h = 6'd2;
            2'd2:    h = 6'd32;
            default: h = 6'd3;
        endcase
        return h;
    endfunction

endpackage

### design/adcc_divider.sv
module adcc_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  adcc_pkg::adcc_div_req_t             req,
    output logic                                done,
    output logic [adcc_pkg::CODE_BITS-1:0]      code
);

    localparam int LW = adcc_pkg::LEVEL_BITS;
    localparam int QW = adcc_pkg::CODE_BITS;
    localparam int PW = LW + QW;
    localparam int CW = $clog2(QW);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;

    logic [1:0]    st_reg, st_next;
    logic [LW-1:0] diff_reg, diff_next;
    logic [LW-1:0] span_reg, span_next;
    logic [QW-1:0] scale_reg, scale_next;
    logic [PW-1:0] work_reg, work_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] code_reg, code_next;
    logic          done_reg, done_next;

    logic [QW-1:0] ones;
    logic [QW-1:0] scale_w;
    logic [LW:0]   shifted;
    logic [LW:0]   trial;
    logic [LW-1:0] new_rem;
    logic          qbit;
    logic [PW-1:0] step_work;

    // Full scale mask from the resolution
    assign ones    = '1;
    assign scale_w = ones >> (5'(QW) - {1'b0, req.conv_bits});

    // One restoring divide step on the partial remainder
    assign shifted   = {work_reg[PW-1:QW], work_reg[QW-1]};
    assign trial     = shifted - {1'b0, span_reg};
    assign qbit      = !trial[LW];
    assign new_rem   = qbit ? trial[LW-1:0] : shifted[LW-1:0];
    assign step_work = {new_rem, work_reg[QW-2:0], qbit};

    always_comb begin
        st_next    = st_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        scale_next = scale_reg;
        work_next  = work_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        done_next  = 1'b0;
        case (st_reg)
            D_IDLE: begin
                if (start) begin
                    // Settle empty span and out-of-span samples at once
                    if (req.ref_high <= req.ref_low || req.sample <= req.ref_low) begin
                        code_next = '0;
                        done_next = 1'b1;
                    end else if (req.sample >= req.ref_high) begin
                        code_next = scale_w;
                        done_next = 1'b1;
                    end else begin
                        diff_next  = req.sample - req.ref_low;
                        span_next  = req.ref_high - req.ref_low;
                        scale_next = scale_w;
                        st_next    = D_MUL;
                    end
                end
            end
            D_MUL: begin
                work_next = PW'(scale_reg) * PW'(diff_reg);
                cnt_next  = CW'(QW - 1);
                st_next   = D_DIV;
            end
            D_DIV: begin
                work_next = step_work;
                if (cnt_reg == '0) begin
                    code_next = step_work[QW-1:0];
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        diff_reg  <= diff_next;
        span_reg  <= span_next;
        scale_reg <= scale_next;
        work_reg  <= work_next;
        cnt_reg   <= cnt_next;
        code_reg  <= code_next;
    end

    assign done = done_reg;
    assign code = code_reg;

endmodule

### design/adc_conversion_controller_core.sv
// A/D converter control-register front.
// Input channel (s_): one request per control register write or per
// instruction-cycle tick. Result channel (m_): one result per request, with
// the control readback, both result bytes, the selected channel, busy and the
// conversion-complete interrupt pulse.
// Configuration: APB-style port, registers at byte addresses 4*i; pready is
// always high. Write it only while the block is idle.
// Timing: a write or a tick that does not finish a conversion gives its
// result in the cycle after acceptance. A tick that finishes a conversion
// goes through set-up, one multiply, 15 restoring divide steps in the
// divider and a store of the result bytes; a zero or full-scale code skips
// the multiply and divide steps. The block takes no request meanwhile.
// Throughput: one request per cycle while the result register drains, else
// bounded by the divider for completing ticks.
// Reset: control register, phase, counters and result bytes clear;
// configuration returns to 8-bit resolution, one-byte layout, no analog pins,
// supply and zero references.
// Stall: a waiting result is held in the output register; a new request is
// taken in the cycle the receiver takes the waiting one.
module adc_conversion_controller_core #(
    parameter int CHANNELS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  adcc_pkg::adcc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output adcc_pkg::adcc_out_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adcc_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int LW = adcc_pkg::LEVEL_BITS;
    localparam int QW = adcc_pkg::CODE_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;

    // Configuration registers
    logic [3:0] bits_reg;
    logic       split_reg;
    logic       rj_reg;
    logic [7:0] amask_reg;
    logic [3:0] rhc_reg;
    logic [3:0] rlc_reg;

    // Converter state
    logic          st_reg, st_next;
    logic [7:0]    ctrl_reg, ctrl_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [LW-1:0] hs_reg, hs_next;
    logic [LW-1:0] hh_reg, hh_next;
    logic [LW-1:0] hl_reg, hl_next;
    logic [7:0]    rh_reg, rh_next;
    logic [7:0]    rl_reg, rl_next;
    logic          m_valid_reg, m_valid_next;
    adcc_pkg::adcc_out_t m_data_reg, m_data_next;

    logic                    accept;
    logic                    cfg_wr;
    logic                    load;
    logic                    pulse;
    logic                    div_start;
    logic                    div_done;
    logic [QW-1:0]           div_code;
    adcc_pkg::adcc_div_req_t div_req;
    logic [5:0]              ht_cur;
    logic [5:0]              ht_new;

    // Level of a channel pin, zero when not an analog input
    function automatic logic [LW-1:0] chan_level(input logic [3:0] ch,
                                                 input logic [7:0] mask,
                                                 input logic [LW-1:0] lvl);
        logic [LW-1:0] r;
        r = '0;
        if (ch < 4'(CHANNELS) && mask[ch[2:0]]) begin
            r = lvl;
        end
        return r;
    endfunction

    assign accept = s_valid && s_ready;
    assign s_ready = (st_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    assign ht_cur = adcc_pkg::half_tad(ctrl_reg[7:6]);
    assign ht_new = adcc_pkg::half_tad(s_data.write_data[7:6]);

    assign div_req.sample    = hs_reg;
    assign div_req.ref_high  = hh_reg;
    assign div_req.ref_low   = hl_reg;
    assign div_req.conv_bits = bits_reg;

    adcc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .done    (div_done),
        .code    (div_code)
    );

    // Sequence requests and conversion completion
    always_comb begin
        st_next    = st_reg;
        ctrl_next  = ctrl_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hs_next    = hs_reg;
        hh_next    = hh_reg;
        hl_next    = hl_reg;
        rh_next    = rh_reg;
        rl_next    = rl_reg;
        load       = 1'b0;
        pulse      = 1'b0;
        div_start  = 1'b0;
        if (accept) begin
            if (s_data.kind == adcc_pkg::KIND_WRITE) begin
                ctrl_next = s_data.write_data;
                load      = 1'b1;
                if (s_data.write_data[adcc_pkg::BIT_ADON]) begin
                    // Start or restart acquisition on a GO rise
                    if (s_data.write_data[adcc_pkg::BIT_GO] && !ctrl_reg[adcc_pkg::BIT_GO]) begin
                        cnt_next   = {2'b00, ht_new};
                        phase_next = adcc_pkg::PH_ACQ;
                    end
                end else begin
                    phase_next = adcc_pkg::PH_IDLE;
                end
            end else if (phase_reg == adcc_pkg::PH_ACQ || phase_reg == adcc_pkg::PH_CONV) begin
                if (cnt_reg > 8'd1) begin
                    cnt_next = cnt_reg - 8'd1;
                    load     = 1'b1;
                end else if (phase_reg == adcc_pkg::PH_ACQ) begin
                    // Sample the channel and both references
                    hs_next = chan_level({1'b0, ctrl_reg[5:3]}, amask_reg,
                                         s_data.sample_level);
                    hh_next = (rhc_reg < 4'(CHANNELS))
                        ? chan_level(rhc_reg, amask_reg, s_data.ref_high_level)
                        : s_data.supply_level;
                    hl_next = (rlc_reg < 4'(CHANNELS))
                        ? chan_level(rlc_reg, amask_reg, s_data.ref_low_level)
                        : '0;
                    cnt_next   = 8'({2'b00, ht_cur} * 8'd5);
                    phase_next = adcc_pkg::PH_CONV;
                    load       = 1'b1;
                end else begin
                    // Hand the conversion to the divider
                    div_start = 1'b1;
                    st_next   = ST_CONV;
                end
            end else begin
                load = 1'b1;
            end
        end else if (st_reg == ST_CONV && div_done) begin
            // Store the result bytes in the chosen layout
            if (split_reg) begin
                if (rj_reg) begin
                    rl_next = div_code[7:0];
                    rh_next = {6'b000000, div_code[9:8]};
                end else begin
                    rl_next = {div_code[1:0], 6'b000000};
                    rh_next = div_code[9:2];
                end
            end else begin
                rh_next = div_code[7:0];
            end
            ctrl_next = ctrl_reg;
            ctrl_next[adcc_pkg::BIT_GO]   = 1'b0;
            ctrl_next[adcc_pkg::BIT_ADIF] = 1'b1;
            cnt_next   = 8'd0;
            phase_next = adcc_pkg::PH_IDLE;
            st_next    = ST_IDLE;
            load       = 1'b1;
            pulse      = 1'b1;
        end
    end

    // Build the result from the updated state
    always_comb begin
        m_data_next                  = m_data_reg;
        m_valid_next                 = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next                 = 1'b1;
            m_data_next.control_value    = ctrl_next;
            m_data_next.result_high      = rh_next;
            m_data_next.result_low       = rl_next;
            m_data_next.selected_channel = ctrl_next[5:3];
            m_data_next.busy_res         = (phase_next != adcc_pkg::PH_IDLE);
            m_data_next.interrupt_pulse  = pulse;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            ctrl_reg    <= '0;
            phase_reg   <= adcc_pkg::PH_IDLE;
            cnt_reg     <= '0;
            hs_reg      <= '0;
            hh_reg      <= '0;
            hl_reg      <= '0;
            rh_reg      <= '0;
            rl_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            ctrl_reg    <= ctrl_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            hs_reg      <= hs_next;
            hh_reg      <= hh_next;
            hl_reg      <= hl_next;
            rh_reg      <= rh_next;
            rl_reg      <= rl_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= 4'd8;
            split_reg <= 1'b0;
            rj_reg    <= 1'b0;
            amask_reg <= 8'd0;
            rhc_reg   <= 4'd8;
            rlc_reg   <= 4'd8;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                adcc_pkg::REG_CONVERTER_BITS: bits_reg  <= pwdata[3:0];
                adcc_pkg::REG_SPLIT_RESULT:   split_reg <= pwdata[0];
                adcc_pkg::REG_RIGHT_JUSTIFY:  rj_reg    <= pwdata[0];
                adcc_pkg::REG_ANALOG_MASK:    amask_reg <= pwdata[7:0];
                adcc_pkg::REG_REF_HIGH_CHAN:  rhc_reg   <= pwdata[3:0];
                adcc_pkg::REG_REF_LOW_CHAN:   rlc_reg   <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[4:2])
            adcc_pkg::REG_CONVERTER_BITS: prdata = {28'd0, bits_reg};
            adcc_pkg::REG_SPLIT_RESULT:   prdata = {31'd0, split_reg};
            adcc_pkg::REG_RIGHT_JUSTIFY:  prdata = {31'd0, rj_reg};
            adcc_pkg::REG_ANALOG_MASK:    prdata = {24'd0, amask_reg};
            adcc_pkg::REG_REF_HIGH_CHAN:  prdata = {28'd0, rhc_reg};
            adcc_pkg::REG_REF_LOW_CHAN:   prdata = {28'd0, rlc_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Divider finishes only for a pending conversion with the output free
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == ST_CONV && !m_valid_reg))
        else $error("divider finished with no pending conversion or full output");

    // A pending conversion keeps the converting phase
    a_conv_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CONV) |-> (phase_reg == adcc_pkg::PH_CONV))
        else $error("conversion pending outside converting phase");

    // A completing tick puts the block into the waiting state
    a_start_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (st_reg == ST_CONV && !m_valid_reg))
        else $error("completing tick did not hold off the result");

    // An interrupt result shows GO clear, ADIF set and not busy
    a_irq_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.interrupt_pulse) |->
        (!m_data_reg.control_value[adcc_pkg::BIT_GO] &&
         m_data_reg.control_value[adcc_pkg::BIT_ADIF] && !m_data_reg.busy_res))
        else $error("interrupt result with wrong control bits");

endmodule
